// ----- rtl/core/ordered_list_shift_store_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_SHIFT_STORE_UNIT_DEFINES_SVH
`define ORDERED_LIST_SHIFT_STORE_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define OLSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define OLSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/olss_pkg.sv -----
`default_nettype none
package olss_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WORD_W = 32;
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [CAPACITY-1:0] word_row_t;

  typedef enum logic [2:0] {
    ACT_APPEND      = 3'd0,
    ACT_REMOVE_LAST = 3'd1,
    ACT_INSERT      = 3'd2,
    ACT_REMOVE_AT   = 3'd3,
    ACT_READ        = 3'd4,
    ACT_WRITE       = 3'd5,
    ACT_READ_FIRST  = 3'd6,
    ACT_READ_LAST   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_t;

  typedef cell_op_t [CAPACITY-1:0] cell_op_row_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [CNT_W-1:0] position;
    word_t            value;
  } req_t;

  typedef struct packed {
    word_t            data;
    logic [CNT_W-1:0] count;
    status_t          status;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/ordered_list_shift_store_unit.sv -----
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Every request (append, remove last, insert, remove at, read, write, read
// first, read last) is done at once; on insert or remove the cells from the
// position upward shift toward their neighbor in the same clock. One item is
// taken per cycle; the input stalls only when a result is held by a stalled
// output. The result appears in the output register in the cycle after
// acceptance, and a new item can enter in the same cycle as the previous
// result leaves. Items return the word read or removed (zero otherwise), the
// new count and a status. Reset clears count and rsp_valid, not the entries.
`default_nettype none
module ordered_list_shift_store_unit import olss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  word_row_t    cell_words;
  cell_op_row_t cell_ops;

  olss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cell_words (cell_words),
    .cell_ops   (cell_ops)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t lower_word;
    word_t upper_word;

    if (i == 0) begin : g_first
      assign lower_word = cell_words[i];
    end else begin : g_lower
      assign lower_word = cell_words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_word = cell_words[i];
    end else begin : g_upper
      assign upper_word = cell_words[i+1];
    end

    olss_cell u_cell (
      .clk        (clk),
      .op         (cell_ops[i]),
      .load_word  (req.value),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word       (cell_words[i])
    );
  end

endmodule
`default_nettype wire

// ----- rtl/core/olss_cell.sv -----
`default_nettype none
module olss_cell import olss_pkg::*; (
  input  wire logic     clk,
  input  wire cell_op_t op,
  input  wire word_t    load_word,
  input  wire word_t    lower_word,
  input  wire word_t    upper_word,
  output word_t         word
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       word <= load_word;
      CELL_FROM_LOWER: word <= lower_word;
      CELL_FROM_UPPER: word <= upper_word;
      default:         word <= word;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/olss_ctrl.sv -----
`default_nettype none
module olss_ctrl import olss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_t      req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_t           rsp,
  input  wire word_row_t cell_words,
  output cell_op_row_t   cell_ops
);

  logic             accept;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;
  logic [CNT_W-1:0] at;
  logic             do_ins;
  logic             do_rem;
  logic             do_wr;
  logic             do_rd;
  status_t          status;
  logic             rsp_valid_next;
  word_t            rd_word;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept = req_valid & ~req_stall;

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_wr  = 1'b0;
    do_rd  = 1'b0;
    at     = req.position;
    status = ST_OK;
    case (action_t'(req.action))
      ACT_APPEND: begin
        at = occ;
        if (occ >= CAP_COUNT) status = ST_FULL;
        else do_ins = 1'b1;
      end
      ACT_REMOVE_LAST: begin
        at = occ - CNT_W'(1);
        if (occ == '0) status = ST_EMPTY;
        else begin
          do_rem = 1'b1;
          do_rd  = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (req.position > occ) status = ST_BADPOS;
        else if (occ >= CAP_COUNT) status = ST_FULL;
        else do_ins = 1'b1;
      end
      ACT_REMOVE_AT: begin
        if (req.position >= occ) status = ST_BADPOS;
        else begin
          do_rem = 1'b1;
          do_rd  = 1'b1;
        end
      end
      ACT_READ: begin
        if (req.position >= occ) status = ST_BADPOS;
        else do_rd = 1'b1;
      end
      ACT_WRITE: begin
        if (req.position >= occ) status = ST_BADPOS;
        else do_wr = 1'b1;
      end
      ACT_READ_FIRST: begin
        at = '0;
        if (occ == '0) status = ST_EMPTY;
        else do_rd = 1'b1;
      end
      ACT_READ_LAST: begin
        at = occ - CNT_W'(1);
        if (occ == '0) status = ST_EMPTY;
        else do_rd = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Insert opens a gap at the position, remove closes it; the cells from there up move at once.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ops[i] = CELL_HOLD;
      if (accept) begin
        if (do_ins && (CNT_W'(i) > at)) cell_ops[i] = CELL_FROM_LOWER;
        else if ((do_ins || do_wr) && (CNT_W'(i) == at)) cell_ops[i] = CELL_LOAD;
        else if (do_rem && (CNT_W'(i) >= at)) cell_ops[i] = CELL_FROM_UPPER;
      end
    end
  end

  // Read the old contents, so remove returns the word before the shift.
  assign rd_word = do_rd ? cell_words[at[IDX_W-1:0]] : '0;

  assign occ_next = occ + CNT_W'(do_ins) - CNT_W'(do_rem);
  assign rsp_valid_next = accept | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
      if (accept) occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data   <= rd_word;
      rsp.count  <= occ_next;
      rsp.status <= status;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/olss_checker.sv -----
`default_nettype none
`include "ordered_list_shift_store_unit_defines.svh"
module olss_checker import olss_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  `OLSS_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req), "item moved")
  `OLSS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result moved")
  `OLSS_ASSERT(a_count_cap, rsp_valid |-> rsp.count <= CAP_COUNT, "count above capacity")
  `OLSS_ASSERT(a_fail_no_data, rsp_valid && rsp.status != ST_OK |-> rsp.data == '0, "fail data")
  `OLSS_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && !req_stall, "result after reset")

endmodule

bind ordered_list_shift_store_unit olss_checker u_olss_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
